FILE: sv/pose_tracking_wheel_drive_top_defines.svh
// Assertion macros used by the pose tracking wheel drive port checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef POSE_TRACKING_WHEEL_DRIVE_TOP_DEFINES_SVH
`define POSE_TRACKING_WHEEL_DRIVE_TOP_DEFINES_SVH

// Same-cycle implication
`define PTWD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PTWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ptwd_pkg.sv
// Types, constants and helper functions of the pose tracking wheel drive.
// No dependencies; used by pose_tracking_wheel_drive_top.
`timescale 1ns / 1ps

package ptwd_pkg;

    localparam int POS_FRAC_BITS   = 8;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int ANG_SHIFT       = 30 - ANGLE_FRAC_BITS;

    localparam int POS_W  = 24;
    localparam int HEAD_W = 15;
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 23;
    localparam int VFS_W  = 15;
    localparam int VOLT_W = 16;
    localparam int CFG_DW = 23;
    localparam int CFG_IW = 3;

    localparam int AW   = 35;              // CORDIC angle, Q.30
    localparam int CW   = 33;              // sin / cos, Q.30
    localparam int EW   = POS_W + 1;       // world error
    localparam int HW   = HEAD_W + 1;      // heading error
    localparam int PW   = CW + EW;         // rotation products
    localparam int XW   = 28;              // local error
    localparam int RW   = XW + 11;         // hypot CORDIC lane
    localparam int KW   = 25;
    localparam int HKW  = RW + KW;
    localparam int HYW  = HKW - 32;
    localparam int G1W  = XW + GAIN_W + 1;
    localparam int G3W  = HW + GAIN_W + 1;
    localparam int SW   = G1W + ANGLE_FRAC_BITS + 1;
    localparam int OW   = SW - 8 - POS_FRAC_BITS;
    localparam int HCW  = HYW + CW;
    localparam int OFPW = OW + GAIN_W + 1;
    localparam int VW   = 38;
    localparam int FW   = OFPW - (9 + ANGLE_FRAC_BITS - POS_FRAC_BITS);
    localparam int WW   = FW + 1;
    localparam int DIV_W = 40;
    localparam int QW   = VFS_W;
    localparam int NW   = DIV_W + QW;
    localparam int SHW  = $clog2(WW - DIV_W + 1);

    localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_K_Q30 = 33'sd652032874;
    localparam logic signed [KW-1:0] CORDIC_K_Q24 = 25'sd10188014;

    localparam longint PI_QA_L =
        (64'sd3373259426 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> ANG_SHIFT;
    localparam logic signed [HW-1:0] PI_QA     = HW'(PI_QA_L);
    localparam logic signed [HW-1:0] TWO_PI_QA = HW'(2 * PI_QA_L);

    typedef enum logic [CFG_IW-1:0] {
        REG_GAIN_FORWARD       = 3'd0,
        REG_GAIN_LATERAL       = 3'd1,
        REG_GAIN_HEADING       = 3'd2,
        REG_TRACK_WIDTH        = 3'd3,
        REG_SPEED_LIMIT        = 3'd4,
        REG_VOLTAGE_FULL_SCALE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic                 neg;
        logic signed [AW-1:0] ang;
    } fold_t;

    function automatic logic signed [AW-1:0] atan_q30(input int unsigned i);
        logic signed [AW-1:0] r;
        case (i)
            0:  r = 35'sd843314856;
            1:  r = 35'sd497837829;
            2:  r = 35'sd263043836;
            3:  r = 35'sd133525158;
            4:  r = 35'sd67021686;
            5:  r = 35'sd33543515;
            6:  r = 35'sd16775850;
            7:  r = 35'sd8388437;
            8:  r = 35'sd4194282;
            9:  r = 35'sd2097149;
            10: r = 35'sd1048575;
            11: r = 35'sd524287;
            12: r = 35'sd262143;
            13: r = 35'sd131071;
            14: r = 35'sd65535;
            15: r = 35'sd32767;
            16: r = 35'sd16383;
            17: r = 35'sd8191;
            18: r = 35'sd4095;
            19: r = 35'sd2047;
            20: r = 35'sd1023;
            21: r = 35'sd511;
            22: r = 35'sd255;
            23: r = 35'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Bring a Q.30 angle into [-pi, pi]
    function automatic logic signed [AW-1:0] wrap_q30(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        r = a;
        if (a > PI_Q30)
        begin
            r = a - TWO_PI_Q30;
        end
        else if (a < -PI_Q30)
        begin
            r = a + TWO_PI_Q30;
        end
        return r;
    endfunction

    // Move an angle outside [-pi/2, pi/2] by pi; the results get negated
    function automatic fold_t fold_q30(input logic signed [AW-1:0] a);
        fold_t r;
        r.neg = 1'b0;
        r.ang = a;
        if (a > HALF_PI_Q30)
        begin
            r.neg = 1'b1;
            r.ang = a - PI_Q30;
        end
        else if (a < -HALF_PI_Q30)
        begin
            r.neg = 1'b1;
            r.ang = a + PI_Q30;
        end
        return r;
    endfunction

    function automatic logic signed [HW-1:0] wrap_qa(input logic signed [HW-1:0] a);
        logic signed [HW-1:0] r;
        r = a;
        if (a > PI_QA)
        begin
            r = a - TWO_PI_QA;
        end
        else if (a < -PI_QA)
        begin
            r = a + TWO_PI_QA;
        end
        return r;
    endfunction

endpackage

FILE: sv/pose_tracking_wheel_drive_top.sv
// Pose tracking controller for a two-wheel drive: pose error to wheel voltages.
// Depends on ptwd_pkg for formats, constants and angle helpers.
`timescale 1ns / 1ps

// One pose pair enters per clock unless the full pipeline is stalled at the output
// (pose_ready low), and one voltage word leaves per pose pair. The path runs
// through two parallel 16-stage sin/cos CORDIC chains, a 16-stage hypot
// CORDIC chain and a 15-stage restoring divider for the voltage scaling, one
// step per stage. Valid bits travel with the data and every stage holds while
// the stages after it are full, so bubbles collapse and a waiting result does
// not block new input until the whole pipeline is full. Configuration writes
// apply at once and are meant to happen while the pipeline is empty.
module pose_tracking_wheel_drive_top
    import ptwd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,

    input  logic                     pose_valid,
    output logic                     pose_ready,
    input  logic signed [POS_W-1:0]  current_x,
    input  logic signed [POS_W-1:0]  current_y,
    input  logic signed [HEAD_W-1:0] current_heading,
    input  logic signed [POS_W-1:0]  target_x,
    input  logic signed [POS_W-1:0]  target_y,
    input  logic signed [HEAD_W-1:0] target_heading,

    output logic                     drive_valid,
    input  logic                     drive_ready,
    output logic signed [VOLT_W-1:0] left_voltage,
    output logic signed [VOLT_W-1:0] right_voltage,
    output logic                     scaled_down
);

    localparam int S        = CORDIC_STEPS;
    localparam int ST_DIFF  = 0;
    localparam int ST_WRAP  = 1;
    localparam int ST_EANG  = 2;
    localparam int ST_ROT0  = 3;
    localparam int ST_NEG   = ST_ROT0 + S + 1;
    localparam int ST_MUL   = ST_NEG + 1;
    localparam int ST_LOC   = ST_MUL + 1;
    localparam int ST_HK    = ST_LOC + S + 1;
    localparam int ST_OMG   = ST_HK + 1;
    localparam int ST_HC    = ST_OMG + 1;
    localparam int ST_V     = ST_HC + 1;
    localparam int ST_W     = ST_V + 1;
    localparam int ST_MAG   = ST_W + 1;
    localparam int ST_D     = ST_MAG + 1;
    localparam int ST_NORM  = ST_D + 1;
    localparam int ST_NUM   = ST_NORM + 1;
    localparam int ST_OUT   = ST_NUM + QW + 1;
    localparam int NST      = ST_OUT + 1;

    // ---------------------------------------------------------------- config
    logic [GAIN_W-1:0] gain_forward_reg;
    logic [GAIN_W-1:0] gain_lateral_reg;
    logic [GAIN_W-1:0] gain_heading_reg;
    logic [GAIN_W-1:0] track_width_reg;
    logic [LIM_W-1:0]  speed_limit_reg;
    logic [VFS_W-1:0]  voltage_full_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_forward_reg       <= GAIN_W'(256);
            gain_lateral_reg       <= GAIN_W'(256);
            gain_heading_reg       <= GAIN_W'(256);
            track_width_reg        <= GAIN_W'(3072);
            speed_limit_reg        <= LIM_W'(16384);
            voltage_full_scale_reg <= VFS_W'(12000);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_GAIN_FORWARD:       gain_forward_reg       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_LATERAL:       gain_lateral_reg       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_HEADING:       gain_heading_reg       <= cfg_data[GAIN_W-1:0];
                REG_TRACK_WIDTH:        track_width_reg        <= cfg_data[GAIN_W-1:0];
                REG_SPEED_LIMIT:        speed_limit_reg        <= cfg_data[LIM_W-1:0];
                REG_VOLTAGE_FULL_SCALE: voltage_full_scale_reg <= cfg_data[VFS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    // A stage moves when the output drains or some later stage holds a bubble
    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            en[k] = drive_ready || !(&(vld_reg | ({NST{1'b1}} >> (NST - k))));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= pose_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign pose_ready  = en[0];
    assign drive_valid = vld_reg[NST-1];

    // ------------------------------------------------ errors and angle prep
    logic signed [EW-1:0]     ex0_reg, ey0_reg, ex1_reg, ey1_reg, ex2_reg, ey2_reg;
    logic signed [HW-1:0]     ed0_reg, eth1_reg, eth2_reg;
    logic signed [AW-1:0]     ca0_reg, ea2_reg;
    logic signed [HEAD_W-1:0] th0_reg, th1_reg, th2_reg;
    fold_t                    cf1_reg, cf2_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_DIFF])
        begin
            ex0_reg <= EW'(target_x) - EW'(current_x);
            ey0_reg <= EW'(target_y) - EW'(current_y);
            ed0_reg <= HW'(target_heading) - HW'(current_heading);
            ca0_reg <= wrap_q30(AW'(current_heading) <<< ANG_SHIFT);
            th0_reg <= target_heading;
        end
        if (en[ST_WRAP])
        begin
            ex1_reg  <= ex0_reg;
            ey1_reg  <= ey0_reg;
            eth1_reg <= wrap_qa(ed0_reg);
            cf1_reg  <= fold_q30(ca0_reg);
            th1_reg  <= th0_reg;
        end
        if (en[ST_EANG])
        begin
            ex2_reg  <= ex1_reg;
            ey2_reg  <= ey1_reg;
            eth2_reg <= eth1_reg;
            ea2_reg  <= wrap_q30(AW'(eth1_reg) <<< ANG_SHIFT);
            cf2_reg  <= cf1_reg;
            th2_reg  <= th1_reg;
        end
    end

    // ------------------------------------------ sin/cos CORDIC, two lanes
    // Lane s: current heading. Lane t: heading error.
    logic signed [CW-1:0]     scx_reg [S+1];
    logic signed [CW-1:0]     scy_reg [S+1];
    logic signed [AW-1:0]     sca_reg [S+1];
    logic signed [CW-1:0]     tcx_reg [S+1];
    logic signed [CW-1:0]     tcy_reg [S+1];
    logic signed [AW-1:0]     tca_reg [S+1];
    logic signed [EW-1:0]     rex_reg [S+1];
    logic signed [EW-1:0]     rey_reg [S+1];
    logic signed [HW-1:0]     reth_reg [S+1];
    logic signed [HEAD_W-1:0] rth_reg [S+1];
    logic [S:0]               rsn_reg;
    logic [S:0]               rtn_reg;
    fold_t                    tfold_next;

    assign tfold_next = fold_q30(ea2_reg);

    always_ff @(posedge clk)
    begin
        if (en[ST_ROT0])
        begin
            scx_reg[0]  <= CORDIC_K_Q30;
            scy_reg[0]  <= '0;
            sca_reg[0]  <= cf2_reg.ang;
            rsn_reg[0]  <= cf2_reg.neg;
            tcx_reg[0]  <= CORDIC_K_Q30;
            tcy_reg[0]  <= '0;
            tca_reg[0]  <= tfold_next.ang;
            rtn_reg[0]  <= tfold_next.neg;
            rex_reg[0]  <= ex2_reg;
            rey_reg[0]  <= ey2_reg;
            reth_reg[0] <= eth2_reg;
            rth_reg[0]  <= th2_reg;
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en[ST_ROT0 + 1 + i])
            begin
                if (!sca_reg[i][AW-1])
                begin
                    scx_reg[i+1] <= scx_reg[i] - (scy_reg[i] >>> i);
                    scy_reg[i+1] <= scy_reg[i] + (scx_reg[i] >>> i);
                    sca_reg[i+1] <= sca_reg[i] - atan_q30(i);
                end
                else
                begin
                    scx_reg[i+1] <= scx_reg[i] + (scy_reg[i] >>> i);
                    scy_reg[i+1] <= scy_reg[i] - (scx_reg[i] >>> i);
                    sca_reg[i+1] <= sca_reg[i] + atan_q30(i);
                end
                if (!tca_reg[i][AW-1])
                begin
                    tcx_reg[i+1] <= tcx_reg[i] - (tcy_reg[i] >>> i);
                    tcy_reg[i+1] <= tcy_reg[i] + (tcx_reg[i] >>> i);
                    tca_reg[i+1] <= tca_reg[i] - atan_q30(i);
                end
                else
                begin
                    tcx_reg[i+1] <= tcx_reg[i] + (tcy_reg[i] >>> i);
                    tcy_reg[i+1] <= tcy_reg[i] - (tcx_reg[i] >>> i);
                    tca_reg[i+1] <= tca_reg[i] + atan_q30(i);
                end
                rsn_reg[i+1]  <= rsn_reg[i];
                rtn_reg[i+1]  <= rtn_reg[i];
                rex_reg[i+1]  <= rex_reg[i];
                rey_reg[i+1]  <= rey_reg[i];
                reth_reg[i+1] <= reth_reg[i];
                rth_reg[i+1]  <= rth_reg[i];
            end
        end
    end

    // ---------------------------------------------- rotate into robot frame
    logic signed [CW-1:0]     cs_reg, ss_reg, ct_reg, ct2_reg;
    logic signed [EW-1:0]     exn_reg, eyn_reg;
    logic signed [HW-1:0]     ethn_reg, ethm_reg;
    logic signed [HEAD_W-1:0] thn_reg, thm_reg;
    logic signed [PW-1:0]     pcx_reg, psy_reg, pcy_reg, psx_reg;
    logic signed [PW:0]       xsum_next, ysum_next;
    logic signed [XW-1:0]     xl_next, yl_next, xabs_next;

    always_ff @(posedge clk)
    begin
        if (en[ST_NEG])
        begin
            cs_reg   <= rsn_reg[S] ? -scx_reg[S] : scx_reg[S];
            ss_reg   <= rsn_reg[S] ? -scy_reg[S] : scy_reg[S];
            ct_reg   <= rtn_reg[S] ? -tcx_reg[S] : tcx_reg[S];
            exn_reg  <= rex_reg[S];
            eyn_reg  <= rey_reg[S];
            ethn_reg <= reth_reg[S];
            thn_reg  <= rth_reg[S];
        end
        if (en[ST_MUL])
        begin
            pcx_reg  <= cs_reg * exn_reg;
            psy_reg  <= ss_reg * eyn_reg;
            pcy_reg  <= cs_reg * eyn_reg;
            psx_reg  <= ss_reg * exn_reg;
            ct2_reg  <= ct_reg;
            ethm_reg <= ethn_reg;
            thm_reg  <= thn_reg;
        end
    end

    always_comb
    begin
        xsum_next = (PW+1)'(pcx_reg) + (PW+1)'(psy_reg);
        ysum_next = (PW+1)'(pcy_reg) - (PW+1)'(psx_reg);
        xl_next   = XW'(xsum_next >>> 30);
        yl_next   = XW'(ysum_next >>> 30);
        xabs_next = xl_next[XW-1] ? -xl_next : xl_next;
    end

    // ------------------------------------------------------- hypot CORDIC
    logic signed [RW-1:0]     hx_reg [S+1];
    logic signed [RW-1:0]     hy_reg [S+1];
    logic signed [XW-1:0]     hxl_reg [S+1];
    logic signed [XW-1:0]     hyl_reg [S+1];
    logic signed [CW-1:0]     hct_reg [S+1];
    logic signed [HW-1:0]     heth_reg [S+1];
    logic signed [HEAD_W-1:0] hth_reg [S+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_LOC])
        begin
            hx_reg[0]   <= RW'(xabs_next) <<< 8;
            hy_reg[0]   <= RW'(yl_next) <<< 8;
            hxl_reg[0]  <= xl_next;
            hyl_reg[0]  <= yl_next;
            hct_reg[0]  <= ct2_reg;
            heth_reg[0] <= ethm_reg;
            hth_reg[0]  <= thm_reg;
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_hyp
        always_ff @(posedge clk)
        begin
            if (en[ST_LOC + 1 + i])
            begin
                if (!hy_reg[i][RW-1])
                begin
                    hx_reg[i+1] <= hx_reg[i] + (hy_reg[i] >>> i);
                    hy_reg[i+1] <= hy_reg[i] - (hx_reg[i] >>> i);
                end
                else
                begin
                    hx_reg[i+1] <= hx_reg[i] - (hy_reg[i] >>> i);
                    hy_reg[i+1] <= hy_reg[i] + (hx_reg[i] >>> i);
                end
                hxl_reg[i+1]  <= hxl_reg[i];
                hyl_reg[i+1]  <= hyl_reg[i];
                hct_reg[i+1]  <= hct_reg[i];
                heth_reg[i+1] <= heth_reg[i];
                hth_reg[i+1]  <= hth_reg[i];
            end
        end
    end

    // ------------------------------------------------ speed and turn rate
    logic signed [HKW-1:0]    hk_reg;
    logic signed [G1W-1:0]    p1_reg, p1o_reg, p1h_reg;
    logic signed [G1W-1:0]    p2_reg;
    logic signed [G3W-1:0]    p3_reg;
    logic signed [CW-1:0]     cth_reg, cto_reg;
    logic signed [HEAD_W-1:0] thk_reg;
    logic signed [HYW-1:0]    hyp_reg;
    logic signed [OW-1:0]     omega_reg;
    logic signed [SW-1:0]     sum_next;
    logic signed [HCW-1:0]    hc_reg;
    logic signed [OFPW-1:0]   offp_reg;
    logic signed [VW-1:0]     v_reg;
    logic signed [FW-1:0]     off_reg;
    logic signed [WW-1:0]     vl_reg, vr_reg;

    assign sum_next = (SW'(thk_reg) <<< (8 + POS_FRAC_BITS))
                    + (SW'(p2_reg) <<< ANGLE_FRAC_BITS)
                    + (SW'(p3_reg) <<< POS_FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en[ST_HK])
        begin
            hk_reg  <= hx_reg[S] * CORDIC_K_Q24;
            p1_reg  <= hxl_reg[S] * $signed({1'b0, gain_forward_reg});
            p2_reg  <= hyl_reg[S] * $signed({1'b0, gain_lateral_reg});
            p3_reg  <= heth_reg[S] * $signed({1'b0, gain_heading_reg});
            cth_reg <= hct_reg[S];
            thk_reg <= hth_reg[S];
        end
        if (en[ST_OMG])
        begin
            hyp_reg   <= HYW'(hk_reg >>> 32);
            omega_reg <= OW'(sum_next >>> (8 + POS_FRAC_BITS));
            cto_reg   <= cth_reg;
            p1o_reg   <= p1_reg;
        end
        if (en[ST_HC])
        begin
            hc_reg   <= hyp_reg * cto_reg;
            offp_reg <= omega_reg * $signed({1'b0, track_width_reg});
            p1h_reg  <= p1o_reg;
        end
        if (en[ST_V])
        begin
            v_reg   <= VW'(hc_reg >>> 30) + VW'(p1h_reg >>> 8);
            off_reg <= FW'(offp_reg >>> (9 + ANGLE_FRAC_BITS - POS_FRAC_BITS));
        end
        if (en[ST_W])
        begin
            vl_reg <= WW'(v_reg) - WW'(off_reg);
            vr_reg <= WW'(v_reg) + WW'(off_reg);
        end
    end

    // -------------------------------------------------- limit and normalize
    logic [WW-1:0]     ml_reg, mr_reg, ml2_reg, mr2_reg, d_reg;
    logic              nl_reg, nr_reg, nl2_reg, nr2_reg, nl3_reg, nr3_reg;
    logic              sc_reg, sc3_reg;
    logic [WW-1:0]     mmax_next, lim_next;
    logic [SHW-1:0]    nshift_next;
    logic [DIV_W-1:0]  dn_reg, al_reg, ar_reg;

    always_comb
    begin
        mmax_next = (ml_reg > mr_reg) ? ml_reg : mr_reg;
        lim_next  = (speed_limit_reg == '0) ? WW'(1) : WW'(speed_limit_reg);
    end

    // Halve divisor and dividend together until the divisor fits DIV_W bits
    always_comb
    begin
        nshift_next = '0;
        for (int b = DIV_W; b < WW; b++)
        begin
            if (d_reg[b])
            begin
                nshift_next = SHW'(b - DIV_W + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MAG])
        begin
            ml_reg <= vl_reg[WW-1] ? WW'(-vl_reg) : WW'(vl_reg);
            mr_reg <= vr_reg[WW-1] ? WW'(-vr_reg) : WW'(vr_reg);
            nl_reg <= vl_reg[WW-1];
            nr_reg <= vr_reg[WW-1];
        end
        if (en[ST_D])
        begin
            sc_reg  <= mmax_next > lim_next;
            d_reg   <= (mmax_next > lim_next) ? mmax_next : lim_next;
            ml2_reg <= ml_reg;
            mr2_reg <= mr_reg;
            nl2_reg <= nl_reg;
            nr2_reg <= nr_reg;
        end
        if (en[ST_NORM])
        begin
            dn_reg  <= DIV_W'(d_reg >> nshift_next);
            al_reg  <= DIV_W'(ml2_reg >> nshift_next);
            ar_reg  <= DIV_W'(mr2_reg >> nshift_next);
            nl3_reg <= nl2_reg;
            nr3_reg <= nr2_reg;
            sc3_reg <= sc_reg;
        end
    end

    // ------------------------------------------------ restoring divider
    // Quotient never exceeds voltage_full_scale, so QW steps cover it.
    logic [DIV_W-1:0] dv_reg [QW];
    logic [NW-1:0]    rl_reg [QW+1];
    logic [NW-1:0]    rr_reg [QW+1];
    logic [QW-1:0]    ql_reg [QW+1];
    logic [QW-1:0]    qr_reg [QW+1];
    logic [QW:0]      dnl_reg, dnr_reg, dsc_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_NUM])
        begin
            rl_reg[0]  <= al_reg * voltage_full_scale_reg;
            rr_reg[0]  <= ar_reg * voltage_full_scale_reg;
            ql_reg[0]  <= '0;
            qr_reg[0]  <= '0;
            dv_reg[0]  <= dn_reg;
            dnl_reg[0] <= nl3_reg;
            dnr_reg[0] <= nr3_reg;
            dsc_reg[0] <= sc3_reg;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [NW-1:0] dsh;

        assign dsh = NW'(dv_reg[j]) << (QW - 1 - j);

        always_ff @(posedge clk)
        begin
            if (en[ST_NUM + 1 + j])
            begin
                if (rl_reg[j] >= dsh)
                begin
                    rl_reg[j+1] <= rl_reg[j] - dsh;
                    ql_reg[j+1] <= {ql_reg[j][QW-2:0], 1'b1};
                end
                else
                begin
                    rl_reg[j+1] <= rl_reg[j];
                    ql_reg[j+1] <= {ql_reg[j][QW-2:0], 1'b0};
                end
                if (rr_reg[j] >= dsh)
                begin
                    rr_reg[j+1] <= rr_reg[j] - dsh;
                    qr_reg[j+1] <= {qr_reg[j][QW-2:0], 1'b1};
                end
                else
                begin
                    rr_reg[j+1] <= rr_reg[j];
                    qr_reg[j+1] <= {qr_reg[j][QW-2:0], 1'b0};
                end
                dnl_reg[j+1] <= dnl_reg[j];
                dnr_reg[j+1] <= dnr_reg[j];
                dsc_reg[j+1] <= dsc_reg[j];
            end
        end

        if (j < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[ST_NUM + 1 + j])
                begin
                    dv_reg[j+1] <= dv_reg[j];
                end
            end
        end
    end

    // ------------------------------------------------------------- output
    logic signed [VOLT_W-1:0] left_voltage_reg, right_voltage_reg;
    logic                     scaled_down_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            left_voltage_reg  <= dnl_reg[QW] ? -$signed({1'b0, ql_reg[QW]})
                                             : $signed({1'b0, ql_reg[QW]});
            right_voltage_reg <= dnr_reg[QW] ? -$signed({1'b0, qr_reg[QW]})
                                             : $signed({1'b0, qr_reg[QW]});
            scaled_down_reg   <= dsc_reg[QW];
        end
    end

    assign left_voltage  = left_voltage_reg;
    assign right_voltage = right_voltage_reg;
    assign scaled_down   = scaled_down_reg;

endmodule

FILE: sv/ptwd_checker.sv
// Port-level checks for pose_tracking_wheel_drive_top, attached by bind.
// Depends on ptwd_pkg and pose_tracking_wheel_drive_top_defines.svh.
`timescale 1ns / 1ps
`include "pose_tracking_wheel_drive_top_defines.svh"

module ptwd_checker
    import ptwd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_we,
    input logic [CFG_IW-1:0]        cfg_index,
    input logic [CFG_DW-1:0]        cfg_data,
    input logic                     pose_valid,
    input logic                     pose_ready,
    input logic signed [POS_W-1:0]  current_x,
    input logic signed [POS_W-1:0]  current_y,
    input logic signed [HEAD_W-1:0] current_heading,
    input logic signed [POS_W-1:0]  target_x,
    input logic signed [POS_W-1:0]  target_y,
    input logic signed [HEAD_W-1:0] target_heading,
    input logic                     drive_valid,
    input logic                     drive_ready,
    input logic signed [VOLT_W-1:0] left_voltage,
    input logic signed [VOLT_W-1:0] right_voltage,
    input logic                     scaled_down
);

    // Hold a stalled word
    `PTWD_ASSERT_NEXT(a_drive_hold, drive_valid && !drive_ready, drive_valid && $stable(left_voltage) && $stable(right_voltage) && $stable(scaled_down), "drive word changed while stalled")

    // Input backs up only when every stage is full and the output is stalled
    `PTWD_ASSERT_NOW(a_ready_only_on_stall, !pose_ready, drive_valid && !drive_ready, "pose_ready dropped without an output stall")

    // Scaled magnitudes never exceed the 15-bit full scale
    `PTWD_ASSERT_NOW(a_voltage_range, drive_valid, left_voltage != 16'h8000 && right_voltage != 16'h8000, "voltage outside symmetric range")

    // Pipeline comes out of reset empty
    `PTWD_ASSERT_NOW(a_reset_empty, $rose(rst_n), !drive_valid, "drive word present right after reset")

endmodule

bind pose_tracking_wheel_drive_top ptwd_checker u_ptwd_checker (.*);

FILE: tb/sv/ptwd_drive_checker.sv
// Drive checker: predicts voltage words from accepted poses and compares them.
// Depends on ptwd_pkg; instantiated beside the block by testbench.
`timescale 1ns / 1ps

module ptwd_drive_checker
    import ptwd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,
    input  logic                     pose_valid,
    input  logic                     pose_ready,
    input  logic signed [POS_W-1:0]  current_x,
    input  logic signed [POS_W-1:0]  current_y,
    input  logic signed [HEAD_W-1:0] current_heading,
    input  logic signed [POS_W-1:0]  target_x,
    input  logic signed [POS_W-1:0]  target_y,
    input  logic signed [HEAD_W-1:0] target_heading,
    input  logic                     drive_valid,
    input  logic                     drive_ready,
    input  logic signed [VOLT_W-1:0] left_voltage,
    input  logic signed [VOLT_W-1:0] right_voltage,
    input  logic                     scaled_down,
    output int                       errors,
    output int                       pending,
    output int                       drive_words
);

    typedef struct {
        logic signed [VOLT_W-1:0] left;
        logic signed [VOLT_W-1:0] right;
        logic                     scaled;
    } drive_word_t;

    localparam longint ARC_Q30 [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };
    localparam longint PI30   = 64'sd3373259426;
    localparam longint HPI30  = 64'sd1686629713;
    localparam longint PIA    = 64'sd12868;
    localparam int     STEPS  = 16;

    longint unsigned k_fwd, k_lat, k_head, width_l, v_limit, full_mv;
    drive_word_t     drive_q[$];

    // Unit vector of an angle in Q.30
    function automatic void unit_vector(input longint ang, output longint c, output longint s);
        longint x, y, nx, a;
        logic   flip;
        a = ang;
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        while (a > PI30) a -= 2 * PI30;
        while (a < -PI30) a += 2 * PI30;
        if (a > HPI30)
        begin
            a -= PI30;
            flip = 1'b1;
        end
        else if (a < -HPI30)
        begin
            a += PI30;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (a >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                a -= ARC_Q30[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                a += ARC_Q30[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint error_length(input longint a, input longint b);
        longint x, y, nx;
        x = (a < 0 ? -a : a) * 256;
        y = b * 256;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
            end
            x = nx;
        end
        return (x * 64'sd10188014) >>> 32;
    endfunction

    function automatic logic signed [VOLT_W-1:0] millivolts(input longint w,
                                                            input longint unsigned den);
        longint unsigned mag, d, q;
        mag = w < 0 ? -w : w;
        d = den;
        while (d >= (64'd1 << 40))
        begin
            d >>= 1;
            mag >>= 1;
        end
        q = (mag * full_mv) / d;
        return w < 0 ? VOLT_W'(-q) : VOLT_W'(q);
    endfunction

    function automatic drive_word_t predict_drive();
        longint ex, ey, eth, c, s, xl, yl, hyp, v, sum, omega, off, wl, wr;
        longint unsigned ml, mr, m, lim, den;
        drive_word_t r;
        ex  = longint'(target_x) - longint'(current_x);
        ey  = longint'(target_y) - longint'(current_y);
        eth = longint'(target_heading) - longint'(current_heading);
        while (eth > PIA) eth -= 2 * PIA;
        while (eth < -PIA) eth += 2 * PIA;
        unit_vector(longint'(current_heading) * (64'sd1 << 18), c, s);
        xl = (c * ex + s * ey) >>> 30;
        yl = (c * ey - s * ex) >>> 30;
        hyp = error_length(xl, yl);
        unit_vector(eth * (64'sd1 << 18), c, s);
        v = ((hyp * c) >>> 30) + ((longint'(k_fwd) * xl) >>> 8);
        sum = longint'(target_heading) * (64'sd1 << 16)
            + longint'(k_lat) * yl * (64'sd1 << 12)
            + longint'(k_head) * eth * (64'sd1 << 8);
        omega = sum >>> 16;
        off = (longint'(width_l) * omega) >>> 13;
        wl = v - off;
        wr = v + off;
        ml = wl < 0 ? -wl : wl;
        mr = wr < 0 ? -wr : wr;
        m = ml > mr ? ml : mr;
        lim = v_limit != 0 ? v_limit : 1;
        den = m > lim ? m : lim;
        r.left   = millivolts(wl, den);
        r.right  = millivolts(wr, den);
        r.scaled = m > lim;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_fwd   <= 256;
            k_lat   <= 256;
            k_head  <= 256;
            width_l <= 3072;
            v_limit <= 16384;
            full_mv <= 12000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_FORWARD:       k_fwd   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_LATERAL:       k_lat   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_HEADING:       k_head  <= cfg_data[GAIN_W-1:0];
                REG_TRACK_WIDTH:        width_l <= cfg_data[GAIN_W-1:0];
                REG_SPEED_LIMIT:        v_limit <= cfg_data[LIM_W-1:0];
                REG_VOLTAGE_FULL_SCALE: full_mv <= cfg_data[VFS_W-1:0];
                default: ;
            endcase
        end
    end

    initial
    begin
        errors = 0;
        pending = 0;
        drive_words = 0;
    end

    always @(posedge clk)
    begin
        drive_word_t e;
        if (rst_n)
        begin
            if (pose_valid && pose_ready)
                drive_q.push_back(predict_drive());
            if (drive_valid && drive_ready)
            begin
                drive_words++;
                if (drive_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected drive word %0d %0d %0b", $time,
                             left_voltage, right_voltage, scaled_down);
                end
                else
                begin
                    e = drive_q.pop_front();
                    if (e.left !== left_voltage)
                    begin
                        errors++;
                        $display("%0t: left_voltage expected %0d actual %0d", $time,
                                 e.left, left_voltage);
                    end
                    if (e.right !== right_voltage)
                    begin
                        errors++;
                        $display("%0t: right_voltage expected %0d actual %0d", $time,
                                 e.right, right_voltage);
                    end
                    if (e.scaled !== scaled_down)
                    begin
                        errors++;
                        $display("%0t: scaled_down expected %0b actual %0b", $time,
                                 e.scaled, scaled_down);
                    end
                end
            end
            pending = drive_q.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the pose tracking wheel drive testbench: clock, reset, stimulus, verdict.
// Depends on ptwd_pkg, pose_tracking_wheel_drive_top and ptwd_drive_checker.
`timescale 1ns / 1ps

module testbench;
    import ptwd_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic signed [HEAD_W-1:0] ch;
        logic signed [POS_W-1:0]  tx;
        logic signed [POS_W-1:0]  ty;
        logic signed [HEAD_W-1:0] th;
    } pose_pair_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IW-1:0]        cfg_index = '0;
    logic [CFG_DW-1:0]        cfg_data = '0;
    logic                     pose_valid = 1'b0;
    logic                     pose_ready;
    logic signed [POS_W-1:0]  current_x = '0;
    logic signed [POS_W-1:0]  current_y = '0;
    logic signed [HEAD_W-1:0] current_heading = '0;
    logic signed [POS_W-1:0]  target_x = '0;
    logic signed [POS_W-1:0]  target_y = '0;
    logic signed [HEAD_W-1:0] target_heading = '0;
    logic                     drive_valid;
    logic                     drive_ready = 1'b0;
    logic signed [VOLT_W-1:0] left_voltage;
    logic signed [VOLT_W-1:0] right_voltage;
    logic                     scaled_down;
    int                       errors;
    int                       pending;
    int                       drive_words;
    int                       poses_sent = 0;
    bit                       send_gaps = 1'b1;
    bit                       recv_stalls = 1'b1;
    int                       hold_off = 0;

    always #2 clk = ~clk;

    pose_tracking_wheel_drive_top dut (.*);

    ptwd_drive_checker checker_i (.*);

    task automatic offer_pose(input pose_pair_t p);
        bit taken;
        int gap;
        gap = send_gaps ? int'($urandom_range(0, 4)) : 0;
        if (gap > 0)
        begin
            pose_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose_valid      <= 1'b1;
        current_x       <= p.cx;
        current_y       <= p.cy;
        current_heading <= p.ch;
        target_x        <= p.tx;
        target_y        <= p.ty;
        target_heading  <= p.th;
        do
        begin
            @(negedge clk);
            taken = pose_ready;
            @(posedge clk);
        end
        while (!taken);
        poses_sent++;
    endtask

    // Hold valid low and let the pipeline drain
    task automatic drain();
        pose_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DW'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] draw_pos();
        case ($urandom_range(0, 3))
            0: return POS_W'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return POS_W'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic logic signed [HEAD_W-1:0] draw_heading();
        if ($urandom_range(0, 7) == 0)
            return HEAD_W'($urandom);
        return HEAD_W'($signed($urandom_range(0, 25736)) - 12868);
    endfunction

    function automatic pose_pair_t draw_pose();
        pose_pair_t p;
        p.cx = draw_pos();
        p.cy = draw_pos();
        p.ch = draw_heading();
        p.th = draw_heading();
        // Mostly a target near the robot, sometimes anywhere
        if ($urandom_range(0, 3) != 0)
        begin
            p.tx = p.cx + POS_W'($signed($urandom_range(0, 4095)) - 2048);
            p.ty = p.cy + POS_W'($signed($urandom_range(0, 4095)) - 2048);
        end
        else
        begin
            p.tx = draw_pos();
            p.ty = draw_pos();
        end
        return p;
    endfunction

    task automatic random_poses(input int n);
        for (int i = 0; i < n; i++)
            offer_pose(draw_pose());
    endtask

    task automatic directed_poses();
        pose_pair_t p;
        p = '{0, 0, 0, 0, 0, 0};
        offer_pose(p);
        p = '{24'sh800000, 24'sh800000, -15'sd12868, 24'sh7FFFFF, 24'sh7FFFFF, 15'sd12868};
        offer_pose(p);
        p = '{24'sh7FFFFF, 24'sh7FFFFF, 15'sd12868, 24'sh800000, 24'sh800000, -15'sd12868};
        offer_pose(p);
        p = '{0, 0, 15'sh3FFF, 256, 0, 15'sh4000};
        offer_pose(p);
        p = '{0, 0, 15'sh4000, 0, 256, 15'sh3FFF};
        offer_pose(p);
        p = '{100, 100, 15'sd12000, 100, 100, -15'sd12000};
        offer_pose(p);
        p = '{0, 0, 15'sd6434, 1024, -1024, -15'sd6434};
        offer_pose(p);
        p = '{0, 0, 15'sd6435, 0, 0, -15'sd6435};
        offer_pose(p);
        p = '{5000, -5000, 0, 5000, -5000, 0};
        offer_pose(p);
        p = '{0, 0, 0, 24'sh100000, 0, 0};
        offer_pose(p);
        p = '{0, 0, 0, -24'sh100000, 0, 0};
        offer_pose(p);
        p = '{0, 0, 15'sd3217, 0, 24'sh7FFFFF, 15'sd3217};
        offer_pose(p);
        p = '{-1, -1, -15'sd1, 1, 1, 15'sd1};
        offer_pose(p);
        p = '{0, 0, 0, 0, 0, 15'sd12868};
        offer_pose(p);
        p = '{0, 0, 0, 0, 0, -15'sd12868};
        offer_pose(p);
    endtask

    // Receiver: random stalls per word, plus a long hold-off on request
    initial
    begin
        bit got;
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                drive_ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            else if (recv_stalls)
            begin
                wait_cycles = $urandom_range(0, 4);
                if (wait_cycles > 0)
                begin
                    drive_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            drive_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = drive_valid;
                @(posedge clk);
            end
            while (!got && hold_off == 0);
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_poses();
        random_poses(60);
        drain();

        // Extreme gains, narrow track, lowest limit
        write_reg(REG_GAIN_FORWARD, 16'hFFFF);
        write_reg(REG_GAIN_LATERAL, 16'hFFFF);
        write_reg(REG_GAIN_HEADING, 16'hFFFF);
        write_reg(REG_TRACK_WIDTH, 0);
        write_reg(REG_SPEED_LIMIT, 1);
        write_reg(REG_VOLTAGE_FULL_SCALE, 32767);
        directed_poses();
        random_poses(50);
        drain();

        // Zero gains, widest track, highest limit, zero voltage
        write_reg(REG_GAIN_FORWARD, 0);
        write_reg(REG_GAIN_LATERAL, 0);
        write_reg(REG_GAIN_HEADING, 0);
        write_reg(REG_TRACK_WIDTH, 16'hFFFF);
        write_reg(REG_SPEED_LIMIT, 23'h7FFFFF);
        write_reg(REG_VOLTAGE_FULL_SCALE, 0);
        random_poses(40);
        drain();

        // Unused index is dropped; zero limit acts as one
        write_reg(cfg_index_t'(3'd6), 23'h7FFFFF);
        write_reg(cfg_index_t'(3'd7), 0);
        write_reg(REG_SPEED_LIMIT, 0);
        write_reg(REG_VOLTAGE_FULL_SCALE, 12000);
        random_poses(30);
        drain();

        // Back-to-back input against a long receiver hold-off
        write_reg(REG_GAIN_FORWARD, 256);
        write_reg(REG_GAIN_LATERAL, 512);
        write_reg(REG_GAIN_HEADING, 128);
        write_reg(REG_TRACK_WIDTH, 3072);
        write_reg(REG_SPEED_LIMIT, 16384);
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        hold_off = 300;
        random_poses(120);
        drain();

        // Random settings, mixed idling
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_GAIN_FORWARD, $urandom_range(0, 65535));
            write_reg(REG_GAIN_LATERAL, $urandom_range(0, 65535));
            write_reg(REG_GAIN_HEADING, $urandom_range(0, 65535));
            write_reg(REG_TRACK_WIDTH, $urandom_range(0, 65535));
            write_reg(REG_SPEED_LIMIT, $urandom_range(1, 8388607));
            write_reg(REG_VOLTAGE_FULL_SCALE, $urandom_range(0, 32767));
            send_gaps = ph[0];
            recv_stalls = ph[1];
            random_poses(25);
            drain();
        end

        $display("Sent %0d poses over nine settings, checked %0d drive words", poses_sent,
                 drive_words);
        $display("with gaps, stalls, a long output hold-off and a full-drain pause.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
